FILE: rtl/miu_pkg.sv
package miu_pkg;

	// field and datapath widths
	localparam int unsigned DATA_W     = 63;
	localparam int unsigned COEF_W     = 64;
	localparam int unsigned SHIFT_W    = 6;
	localparam int unsigned IN_TDATA_W  = 64;
	localparam int unsigned OUT_TDATA_W = 72;

	// result error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_ZERO   = 2'd1;
	localparam logic [1:0] ERR_NO_INV = 2'd2;

	// outcome of one pass through the shared compare and subtract unit
	typedef struct packed {
		logic              ge;
		logic [DATA_W-1:0] rem_next;
		logic [COEF_W-1:0] coef_next;
	} alu_res_t;

endpackage

FILE: rtl/modular_inverse_unit.sv
// Modular inverse unit: returns value^-1 mod modulus by the extended Euclidean algorithm.
// Input request on s_axis: tdata[62:0] = value. One result request on m_axis:
// tdata[62:0] = inverse, tdata[64:63] = error_code (0 ok, 1 zero input, 2 no inverse).
// The modulus register is written through modulus_wr_en / modulus_wr_data; the user must
// write it only while idle, as the unit itself does not enforce this. One request is worked
// on at a time; s_axis_tready is high only while the unit waits for a new value. Each Euclid
// step runs one binary long division on the shared compare/subtract unit: a setup state,
// an alignment phase that doubles the divisor and then a division phase that develops
// quotient bits k down to 0, where 2^k <= quotient < 2^(k+1) (k = 0 for a zero quotient).
// Zero input or an invalid modulus go straight to the finishing state with no Euclid step.
// The result sits in an output register; when the receiver stalls, the finished
// result holds and the unit waits before writing the next one over it.
// Reset clears the sequencer and the output valid flag and sets the modulus to 2.
module modular_inverse_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                modulus_wr_en,
	input  logic [miu_pkg::DATA_W-1:0]          modulus_wr_data,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [miu_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [62:0] value, [63] unused
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [miu_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // [62:0] inverse,
	                                                           // [64:63] error_code, [71:65] zero
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOOP = 3'd1;
	localparam logic [2:0] ST_NORM = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]                       state_q;
	logic [miu_pkg::DATA_W-1:0]       modulus_q;
	logic [miu_pkg::DATA_W-1:0]       rem_q;
	logic [miu_pkg::DATA_W-1:0]       a_q;
	logic [miu_pkg::COEF_W-1:0]       d_q;
	logic [miu_pkg::COEF_W-1:0]       c0_q;
	logic [miu_pkg::COEF_W-1:0]       c1_q;
	logic [miu_pkg::COEF_W-1:0]       cs_q;
	logic [miu_pkg::SHIFT_W-1:0]      k_q;
	logic [1:0]                       err_q;
	logic                             out_valid_q;
	logic [miu_pkg::DATA_W-1:0]       out_inv_q;
	logic [1:0]                       out_err_q;

	logic [miu_pkg::DATA_W-1:0]       in_value;
	logic                             in_acc;
	logic                             out_free;
	miu_pkg::alu_res_t                alu_res;
	logic [miu_pkg::DATA_W-1:0]       rem_n;
	logic [miu_pkg::COEF_W-1:0]       c_n;
	logic [miu_pkg::COEF_W-1:0]       c_fix;
	logic [miu_pkg::DATA_W-1:0]       inv_n;

	assign in_value      = s_axis_tdata[miu_pkg::DATA_W-1:0];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(miu_pkg::OUT_TDATA_W - miu_pkg::DATA_W - 2){1'b0}},
		out_err_q, out_inv_q};

	// shared compare / subtract unit
	miu_alu u_alu (
		.norm      (state_q == ST_NORM),
		.rem       (rem_q),
		.dvs       (d_q),
		.coef      (c0_q),
		.coef_step (cs_q),
		.res       (alu_res)
	);

	// keep or take the subtraction for this quotient bit
	always_comb begin
		if (alu_res.ge) begin
			rem_n = alu_res.rem_next;
			c_n   = alu_res.coef_next;
		end else begin
			rem_n = rem_q;
			c_n   = c0_q;
		end
	end

	// bring a negative coefficient into range
	always_comb begin
		if (c0_q[miu_pkg::COEF_W-1]) begin
			c_fix = c0_q + {1'b0, modulus_q};
		end else begin
			c_fix = c0_q;
		end
		if (err_q == miu_pkg::ERR_NONE) begin
			inv_n = c_fix[miu_pkg::DATA_W-1:0];
		end else begin
			inv_n = '0;
		end
	end

	// sequencer, modulus register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			modulus_q   <= miu_pkg::DATA_W'(2);
			out_valid_q <= 1'b0;
		end else begin
			if (modulus_wr_en) begin
				modulus_q <= modulus_wr_data;
			end
			// raise valid as a result is loaded, drop it once taken
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_value == '0 || modulus_q < miu_pkg::DATA_W'(2)) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_LOOP;
						end
					end
				end
				ST_LOOP: begin
					if (a_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (!alu_res.ge) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (k_q == '0) begin
						state_q <= ST_LOOP;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Euclid datapath: remainders, shifted divisor and Bezout coefficients
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					rem_q <= in_value;
					a_q   <= modulus_q;
					c0_q  <= miu_pkg::COEF_W'(1);
					c1_q  <= '0;
					if (in_value == '0) begin
						err_q <= miu_pkg::ERR_ZERO;
					end else if (modulus_q < miu_pkg::DATA_W'(2)) begin
						err_q <= miu_pkg::ERR_NO_INV;
					end else begin
						err_q <= miu_pkg::ERR_NONE;
					end
				end
			end
			ST_LOOP: begin
				if (a_q == '0) begin
					if (rem_q != miu_pkg::DATA_W'(1)) begin
						err_q <= miu_pkg::ERR_NO_INV;
					end
				end else begin
					d_q  <= {1'b0, a_q};
					cs_q <= c1_q;
					k_q  <= '0;
				end
			end
			ST_NORM: begin
				// advance the divisor while its double still fits
				if (alu_res.ge) begin
					d_q  <= {d_q[miu_pkg::COEF_W-2:0], 1'b0};
					cs_q <= {cs_q[miu_pkg::COEF_W-2:0], 1'b0};
					k_q  <= k_q + miu_pkg::SHIFT_W'(1);
				end
			end
			ST_DIV: begin
				if (k_q == '0) begin
					// step done: rotate remainders and coefficients
					rem_q <= a_q;
					a_q   <= rem_n;
					c0_q  <= c1_q;
					c1_q  <= c_n;
				end else begin
					rem_q <= rem_n;
					c0_q  <= c_n;
					d_q   <= {1'b0, d_q[miu_pkg::COEF_W-1:1]};
					cs_q  <= {cs_q[miu_pkg::COEF_W-1], cs_q[miu_pkg::COEF_W-1:1]};
					k_q   <= k_q - miu_pkg::SHIFT_W'(1);
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_inv_q <= inv_n;
					out_err_q <= err_q;
				end
			end
			default: begin
			end
		endcase
	end

	// an error result always carries a zero inverse
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[64:63] != miu_pkg::ERR_NONE)
		|-> (m_axis_tdata[62:0] == '0))
		else $error("error result with nonzero inverse");

	// error code stays within its defined set
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[64:63] == miu_pkg::ERR_NONE ||
		m_axis_tdata[64:63] == miu_pkg::ERR_ZERO ||
		m_axis_tdata[64:63] == miu_pkg::ERR_NO_INV))
		else $error("undefined error code");

	// a good inverse lies below the modulus
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[64:63] == miu_pkg::ERR_NONE)
		|-> (m_axis_tdata[62:0] < modulus_q))
		else $error("inverse not reduced");

	// alignment stops once the doubled divisor passes the working remainder
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && $past(state_q == ST_NORM)
		|-> ({d_q, 1'b0} > {2'b00, rem_q}))
		else $error("divisor left short of alignment");

	// a finished result is never overwritten while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("stalled result overwritten");

endmodule

FILE: rtl/miu_alu.sv
module miu_alu (
	input  logic                         norm,
	input  logic [miu_pkg::DATA_W-1:0]   rem,
	input  logic [miu_pkg::COEF_W-1:0]   dvs,
	input  logic [miu_pkg::COEF_W-1:0]   coef,
	input  logic [miu_pkg::COEF_W-1:0]   coef_step,
	output miu_pkg::alu_res_t            res
);

	logic [miu_pkg::COEF_W:0] rhs;
	logic [miu_pkg::COEF_W:0] lhs;

	// pick the doubled divisor while aligning, the divisor itself while dividing
	always_comb begin
		if (norm) begin
			rhs = {dvs, 1'b0};
		end else begin
			rhs = {1'b0, dvs};
		end
		lhs = {{(miu_pkg::COEF_W + 1 - miu_pkg::DATA_W){1'b0}}, rem};
	end

	// compare, then subtract remainder and coefficient in the same pass
	always_comb begin
		res.ge        = (lhs >= rhs);
		res.rem_next  = rem - rhs[miu_pkg::DATA_W-1:0];
		res.coef_next = coef - coef_step;
	end

endmodule
